FILE: rtl/ats_pkg.sv
`default_nettype none

package ats_pkg;

   // Axis geometry and fixed-point formats.
   localparam int AXIS_COUNT_DEF = 6;
   localparam int FIELD_AXES     = 6;
   localparam int AXIS_W         = 32;
   localparam int WEIGHT_W       = 17;
   localparam int BAND_W         = 16;
   localparam int FRAC_W         = 16;
   localparam int CMD_W          = 3;
   localparam int MODE_W         = 2;
   localparam int CSR_IDX_W      = 1;

   // Weight of exactly one in Q1.16.
   localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1 << FRAC_W);

   // Command codes carried by a request.
   typedef enum logic [CMD_W-1:0] {
      CMD_PREPARE   = 3'd0,
      CMD_UNPREPARE = 3'd1,
      CMD_START     = 3'd2,
      CMD_STOP      = 3'd3,
      CMD_SET       = 3'd4,
      CMD_TICK      = 3'd5
   } cmd_type;

   // Arming mode, one-hot internally.
   typedef enum logic [2:0] {
      MODE_NOT_READY = 3'b001,
      MODE_READY     = 3'b010,
      MODE_ARMED     = 3'b100
   } mode_type;

   // Mode as reported on the result channel.
   typedef enum logic [MODE_W-1:0] {
      MODE_CODE_NOT_READY = 2'd0,
      MODE_CODE_READY     = 2'd1,
      MODE_CODE_ARMED     = 2'd2
   } mode_code_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SMOOTHING_WEIGHT = 1'b0,
      REG_ZERO_DEADBAND    = 1'b1
   } csr_idx_type;

   // Per-request orders from the mode controller to every lane.
   typedef struct packed {
      logic clear_target;
      logic load_target;
      logic tick;
   } ctl_type;

   // One result as held in the output stage.
   typedef struct packed {
      logic                                 accepted;
      logic [MODE_W-1:0]                    mode;
      logic                                 publish;
      logic [FIELD_AXES-1:0][AXIS_W-1:0]    axis;
   } rsp_type;

   // Encode the one-hot mode into the reported code.
   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] c;
      c = MODE_CODE_NOT_READY;
      unique case (m)
         MODE_NOT_READY: c = MODE_CODE_NOT_READY;
         MODE_READY:     c = MODE_CODE_READY;
         MODE_ARMED:     c = MODE_CODE_ARMED;
         default:        c = MODE_CODE_NOT_READY;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ats_ctrl.sv
`default_nettype none

module ats_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire logic [ats_pkg::CMD_W-1:0]   command,
   input  wire logic                        switch_ok,
   output ats_pkg::ctl_type                 ctl,
   output logic                             accepted,
   output logic [ats_pkg::MODE_W-1:0]       mode_now
);

   ats_pkg::mode_type mode_ff;
   ats_pkg::mode_type mode_in;

   // Decode the request against the current mode.
   always_comb begin
      mode_in          = mode_ff;
      accepted         = 1'b0;
      ctl.clear_target = 1'b0;
      ctl.load_target  = 1'b0;
      ctl.tick         = 1'b0;
      unique case (ats_pkg::cmd_type'(command))
         ats_pkg::CMD_PREPARE: begin
            if (mode_ff != ats_pkg::MODE_ARMED && switch_ok) begin
               mode_in          = ats_pkg::MODE_READY;
               ctl.clear_target = 1'b1;
               accepted         = 1'b1;
            end
         end
         ats_pkg::CMD_UNPREPARE: begin
            if (mode_ff != ats_pkg::MODE_ARMED && switch_ok) begin
               mode_in  = ats_pkg::MODE_NOT_READY;
               accepted = 1'b1;
            end
         end
         ats_pkg::CMD_START: begin
            if (mode_ff == ats_pkg::MODE_READY) begin
               mode_in  = ats_pkg::MODE_ARMED;
               accepted = 1'b1;
            end
         end
         ats_pkg::CMD_STOP: begin
            if (mode_ff != ats_pkg::MODE_NOT_READY) begin
               mode_in          = ats_pkg::MODE_READY;
               ctl.clear_target = 1'b1;
               accepted         = 1'b1;
            end
         end
         ats_pkg::CMD_SET: begin
            // Outside the armed mode a new target wipes the old one.
            if (mode_ff == ats_pkg::MODE_ARMED) begin
               ctl.load_target = 1'b1;
               accepted        = 1'b1;
            end else begin
               ctl.clear_target = 1'b1;
            end
         end
         ats_pkg::CMD_TICK: begin
            ctl.tick = 1'b1;
            accepted = 1'b1;
         end
         default: begin
         end
      endcase
      if (!fire) begin
         mode_in          = mode_ff;
         ctl.clear_target = 1'b0;
         ctl.load_target  = 1'b0;
         ctl.tick         = 1'b0;
      end
   end

   assign mode_now = ats_pkg::mode_code(mode_in);

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ats_pkg::MODE_NOT_READY;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ats_lane.sv
`default_nettype none

module ats_lane (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ats_pkg::ctl_type                     ctl,
   input  wire logic signed [ats_pkg::AXIS_W-1:0]    target,
   input  wire logic [ats_pkg::WEIGHT_W-1:0]         weight,
   input  wire logic [ats_pkg::BAND_W-1:0]           band,
   output logic signed [ats_pkg::AXIS_W-1:0]         axis_out
);

   localparam int AW     = ats_pkg::AXIS_W;
   localparam int PROD_W = ats_pkg::AXIS_W + ats_pkg::WEIGHT_W + 2;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (ats_pkg::FRAC_W - 1);

   logic signed [AW-1:0]     target_ff;
   logic signed [AW-1:0]     target_in;
   logic signed [AW-1:0]     smoothed_ff;
   logic signed [AW-1:0]     smoothed_in;
   logic signed [AW:0]       diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] sum;
   logic signed [AW-1:0]     quot;
   logic signed [AW:0]       quot_ext;
   logic signed [AW:0]       band_ext;
   logic                     in_band;

   // Target update for this axis.
   always_comb begin
      target_in = target_ff;
      if (ctl.load_target) begin
         target_in = target;
      end else if (ctl.clear_target) begin
         target_in = '0;
      end
   end

   // Filter as target + a * (previous - target), scaled by 2^16, rounded half up.
   always_comb begin
      diff     = {smoothed_ff[AW-1], smoothed_ff} - {target_ff[AW-1], target_ff};
      prod     = PROD_W'($signed({1'b0, weight})) * PROD_W'(diff);
      sum      = prod + (PROD_W'(target_ff) <<< ats_pkg::FRAC_W) + ROUND_HALF;
      quot     = sum[AW+ats_pkg::FRAC_W-1:ats_pkg::FRAC_W];
      quot_ext = {quot[AW-1], quot};
      band_ext = $signed({{(AW+1-ats_pkg::BAND_W){1'b0}}, band});
      in_band  = (quot_ext < band_ext) && (quot_ext > -band_ext);
   end

   assign smoothed_in = ctl.tick ? (in_band ? '0 : quot) : smoothed_ff;
   assign axis_out    = smoothed_in;

   // Axis state.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         smoothed_ff <= '0;
      end else begin
         target_ff   <= target_in;
         smoothed_ff <= smoothed_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ats_merge.sv
`default_nettype none

module ats_merge (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire ats_pkg::rsp_type    rsp_new,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ats_pkg::rsp_type         rsp_out
);

   logic             out_valid_ff;
   logic             skid_valid_ff;
   ats_pkg::rsp_type out_ff;
   ats_pkg::rsp_type skid_ff;
   logic             out_load;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_out   = out_ff;

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff  <= skid_valid_ff || fire;
         skid_valid_ff <= skid_valid_ff && fire;
      end else if (fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Result payload moves; no reset needed.
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
            if (fire) begin
               skid_ff <= rsp_new;
            end
         end else if (fire) begin
            out_ff <= rsp_new;
         end
      end else if (fire) begin
         skid_ff <= rsp_new;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/armed_twist_smoother.sv
// Armed twist smoother: a six-axis velocity target with an exponentially smoothed
// copy, guarded by an arming mode (not ready, ready, armed).
// Request channel: req_valid with req_command, req_switch_ok and six Q8.24 targets;
// a request is taken at a clock edge with req_valid high and req_stall low.
// Every request gives exactly one response on the rsp_ channel, taken at an edge
// with rsp_valid high and rsp_stall low: whether the command succeeded, the mode
// after it, the publish flag and the six smoothed axes.
// Responses are registered in the output stage; one request is taken every cycle
// while req_stall is low. Each axis lane's multiply-add loop on the smoothed value
// closes through its register, which sets that rate for back-to-back filter ticks.
// A stalled response holds; one more request lands in a skid entry, after which
// req_stall rises until the receiver takes a response.
// The user must write registers through csr_ (index 0 smoothing weight, 1 deadband)
// only while the block is idle, not enforced by the block; csr_ready is always high.
// Synchronous reset returns the mode to not ready, clears targets and smoothed
// values, loads the register defaults and empties the output stage.
`default_nettype none

module armed_twist_smoother #(
   parameter int AXIS_COUNT = ats_pkg::AXIS_COUNT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [ats_pkg::CMD_W-1:0]             req_command,
   input  wire logic                                  req_switch_ok,
   input  wire logic signed [ats_pkg::AXIS_W-1:0]     req_lin_x,
   input  wire logic signed [ats_pkg::AXIS_W-1:0]     req_lin_y,
   input  wire logic signed [ats_pkg::AXIS_W-1:0]     req_lin_z,
   input  wire logic signed [ats_pkg::AXIS_W-1:0]     req_ang_x,
   input  wire logic signed [ats_pkg::AXIS_W-1:0]     req_ang_y,
   input  wire logic signed [ats_pkg::AXIS_W-1:0]     req_ang_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_accepted,
   output logic [ats_pkg::MODE_W-1:0]                 rsp_mode_now,
   output logic                                       rsp_publish_enable,
   output logic signed [ats_pkg::AXIS_W-1:0]          rsp_out_lin_x,
   output logic signed [ats_pkg::AXIS_W-1:0]          rsp_out_lin_y,
   output logic signed [ats_pkg::AXIS_W-1:0]          rsp_out_lin_z,
   output logic signed [ats_pkg::AXIS_W-1:0]          rsp_out_ang_x,
   output logic signed [ats_pkg::AXIS_W-1:0]          rsp_out_ang_y,
   output logic signed [ats_pkg::AXIS_W-1:0]          rsp_out_ang_z,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ats_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [ats_pkg::WEIGHT_W-1:0]          csr_wdata
);

   localparam int AW = ats_pkg::AXIS_W;
   localparam int FA = ats_pkg::FIELD_AXES;

   logic                           fire;
   ats_pkg::ctl_type               ctl;
   logic                           ctl_accepted;
   logic [ats_pkg::MODE_W-1:0]     ctl_mode;
   logic [ats_pkg::WEIGHT_W-1:0]   weight_ff;
   logic [ats_pkg::BAND_W-1:0]     band_ff;
   logic [FA-1:0][AW-1:0]          req_axis;
   logic [AXIS_COUNT-1:0][AW-1:0]  lane_axis;
   logic [FA-1:0][AW-1:0]          rsp_axis;
   ats_pkg::rsp_type               rsp_new;
   ats_pkg::rsp_type               rsp_out;

   assign fire      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration registers; a weight above one is held as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= ats_pkg::WEIGHT_W'(52429);
         band_ff   <= ats_pkg::BAND_W'(17);
      end else if (csr_valid && csr_ready) begin
         unique case (ats_pkg::csr_idx_type'(csr_index))
            ats_pkg::REG_SMOOTHING_WEIGHT: begin
               weight_ff <= csr_wdata[ats_pkg::WEIGHT_W-1] ? ats_pkg::ONE_Q16 : csr_wdata;
            end
            ats_pkg::REG_ZERO_DEADBAND: begin
               band_ff <= csr_wdata[ats_pkg::BAND_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Mode controller.
   ats_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .command   (req_command),
      .switch_ok (req_switch_ok),
      .ctl       (ctl),
      .accepted  (ctl_accepted),
      .mode_now  (ctl_mode)
   );

   // Request axes in field order.
   assign req_axis[0] = req_lin_x;
   assign req_axis[1] = req_lin_y;
   assign req_axis[2] = req_lin_z;
   assign req_axis[3] = req_ang_x;
   assign req_axis[4] = req_ang_y;
   assign req_axis[5] = req_ang_z;

   // One filter lane per axis; lanes without a request field see a zero target.
   for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
      logic signed [AW-1:0] lane_target;
      logic signed [AW-1:0] lane_out;
      if (g < FA) begin : g_fed
         assign lane_target = req_axis[g];
      end else begin : g_unfed
         assign lane_target = '0;
      end
      ats_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .target   (lane_target),
         .weight   (weight_ff),
         .band     (band_ff),
         .axis_out (lane_out)
      );
      assign lane_axis[g] = lane_out;
   end

   // Gather lane results into the response; missing lanes read zero.
   for (genvar j = 0; j < FA; j++) begin : g_gather
      if (j < AXIS_COUNT) begin : g_live
         assign rsp_axis[j] = lane_axis[j];
      end else begin : g_dead
         assign rsp_axis[j] = '0;
      end
   end

   always_comb begin
      rsp_new.accepted = ctl_accepted;
      rsp_new.mode     = ctl_mode;
      rsp_new.publish  = (ctl_mode != ats_pkg::MODE_CODE_NOT_READY);
      rsp_new.axis     = rsp_axis;
   end

   // Output stage.
   ats_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rsp_new   (rsp_new),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp_out)
   );

   assign rsp_accepted       = rsp_out.accepted;
   assign rsp_mode_now       = rsp_out.mode;
   assign rsp_publish_enable = rsp_out.publish;
   assign rsp_out_lin_x      = rsp_out.axis[0];
   assign rsp_out_lin_y      = rsp_out.axis[1];
   assign rsp_out_lin_z      = rsp_out.axis[2];
   assign rsp_out_ang_x      = rsp_out.axis[3];
   assign rsp_out_ang_y      = rsp_out.axis[4];
   assign rsp_out_ang_z      = rsp_out.axis[5];

   // A taken request always shows up as a pending response in the next cycle.
   a_fire_then_valid: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("request taken but no response pending");

   // The skid entry only fills behind a held output register.
   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request side stalled with an empty output stage");

   // Reset empties the output stage.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output stage not empty after reset");

endmodule

`default_nettype wire
